@@ hdl/cmta_pkg.sv @@
// ----------------------------------------------------------------------------
// cmta_pkg
// Shared types and codes of the channel moment and tail accumulator: request
// and result payloads, configuration image, stage record and status codes.
// ----------------------------------------------------------------------------
package cmta_pkg;

    // largest channel count the storage is laid out for
    localparam int MAX_CHANNELS = 4;

    // result status codes, also the latched error code
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ORDER    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_WEIGHT   = 3'd3,
        ST_SEQUENCE = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_RANGE_A_START = 3'd0,
        REG_RANGE_A_COUNT = 3'd1,
        REG_RANGE_B_START = 3'd2,
        REG_RANGE_B_COUNT = 3'd3,
        REG_TAIL_LIMIT_0  = 3'd4,
        REG_TAIL_LIMIT_1  = 3'd5,
        REG_TAIL_LIMIT_2  = 3'd6,
        REG_TAIL_LIMIT_3  = 3'd7
    } reg_index_t;

    // request function codes
    typedef enum logic {
        FUNC_CLEAR = 1'b0,
        FUNC_ACCUM = 1'b1
    } func_t;

    // request payload
    typedef struct packed {
        logic               func;
        logic [63:0]        sample_id;
        logic [1:0]         channel;
        logic signed [31:0] contribution;
        logic [31:0]        weight;
    } cmta_in_t;

    // result payload
    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        samples_seen;
        logic signed [47:0] running_sum;
        logic [63:0]        running_square_sum;
        logic [31:0]        peak_magnitude;
        logic [31:0]        tail_hits;
        logic [47:0]        tail_excess_total;
        logic [47:0]        weight_total;
        logic [63:0]        weight_square_total;
    } cmta_out_t;

    // configuration image
    typedef struct packed {
        logic [63:0]                   range_a_start;
        logic [63:0]                   range_a_count;
        logic [63:0]                   range_b_start;
        logic [63:0]                   range_b_count;
        logic [MAX_CHANNELS-1:0][30:0] tail_limit;
    } cmta_cfg_t;

    // request after the first stage: magnitude, squares and config checks
    typedef struct packed {
        logic               func;
        logic [63:0]        sample_id;
        logic [1:0]         channel;
        logic signed [31:0] contribution;
        logic [31:0]        weight;
        logic [31:0]        magnitude;
        logic [63:0]        square;
        logic [63:0]        weight_square;
        logic               id_in_range;
        logic               tail_hit;
        logic [31:0]        excess;
    } cmta_prep_t;

endpackage

@@ hdl/cmta_stream_if.sv @@
// ----------------------------------------------------------------------------
// cmta_stream_if
// Valid/ready channel carrying one payload; a request moves when valid and
// ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface cmta_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

@@ hdl/cmta_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// cmta_cfg_regs
// Configuration registers: identity ranges and per-channel tail limits,
// written through a plain write port.
// ----------------------------------------------------------------------------
module cmta_cfg_regs #(
    parameter int CHANNELS = 4,
    parameter int RANGES   = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    output cmta_pkg::cmta_cfg_t  cfg
);

    logic [7:0]  wr_sel;
    logic [63:0] range_a_start_reg;
    logic [63:0] range_a_count_reg;
    logic [63:0] range_b_start;
    logic [63:0] range_b_count;
    logic [cmta_pkg::MAX_CHANNELS-1:0][30:0] tail_limit;

    // one-hot write decode
    assign wr_sel = cfg_write ? (8'd1 << cfg_index) : 8'd0;

    // range a
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_a_start_reg <= '0;
            range_a_count_reg <= '0;
        end
        else
        begin
            if (wr_sel[cmta_pkg::REG_RANGE_A_START])
                range_a_start_reg <= cfg_data;
            if (wr_sel[cmta_pkg::REG_RANGE_A_COUNT])
                range_a_count_reg <= cfg_data;
        end
    end

    // range b, present only with two ranges; a zero count disables it
    if (RANGES > 1)
    begin : g_range_b
        logic [63:0] b_start_reg;
        logic [63:0] b_count_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                b_start_reg <= '0;
                b_count_reg <= '0;
            end
            else
            begin
                if (wr_sel[cmta_pkg::REG_RANGE_B_START])
                    b_start_reg <= cfg_data;
                if (wr_sel[cmta_pkg::REG_RANGE_B_COUNT])
                    b_count_reg <= cfg_data;
            end
        end

        assign range_b_start = b_start_reg;
        assign range_b_count = b_count_reg;
    end
    else
    begin : g_no_range_b
        assign range_b_start = '0;
        assign range_b_count = '0;
    end

    // tail limits for the channels in use
    for (genvar g = 0; g < cmta_pkg::MAX_CHANNELS; g++)
    begin : g_limit
        if (g < CHANNELS)
        begin : g_used
            logic [30:0] limit_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    limit_reg <= '0;
                else if (wr_sel[int'(cmta_pkg::REG_TAIL_LIMIT_0) + g])
                    limit_reg <= cfg_data[30:0];
            end

            assign tail_limit[g] = limit_reg;
        end
        else
        begin : g_unused
            assign tail_limit[g] = '0;
        end
    end

    // configuration image
    always_comb
    begin
        cfg.range_a_start = range_a_start_reg;
        cfg.range_a_count = range_a_count_reg;
        cfg.range_b_start = range_b_start;
        cfg.range_b_count = range_b_count;
        cfg.tail_limit    = tail_limit;
    end

endmodule

@@ hdl/cmta_prep.sv @@
// ----------------------------------------------------------------------------
// cmta_prep
// First stage: takes a request and registers its magnitude, the squares of
// contribution and weight, the range check and the tail test.
// ----------------------------------------------------------------------------
module cmta_prep (
    input  logic                  clk,
    input  logic                  rst_n,
    cmta_stream_if.sink           contrib,
    input  cmta_pkg::cmta_cfg_t   cfg,
    input  logic                  advance,
    output logic                  prep_valid,
    output cmta_pkg::cmta_prep_t  prep
);

    logic                 valid_reg;
    logic                 valid_next;
    cmta_pkg::cmta_prep_t prep_reg;
    cmta_pkg::cmta_prep_t prep_next;
    logic                 take;
    logic [31:0]          raw;
    logic [31:0]          mag;
    logic [31:0]          limit;
    logic [63:0]          diff_a;
    logic [63:0]          diff_b;
    logic                 in_a;
    logic                 in_b;

    // stage frees up when empty or when its content moves on
    assign contrib.ready = !valid_reg || advance;
    assign take          = contrib.valid && contrib.ready;

    // magnitude of the signed contribution, the most negative value gives 2^31
    assign raw = contrib.payload.contribution;
    assign mag = raw[31] ? (~raw + 32'd1) : raw;

    // identity inside an enabled range
    assign diff_a = contrib.payload.sample_id - cfg.range_a_start;
    assign diff_b = contrib.payload.sample_id - cfg.range_b_start;
    assign in_a   = (contrib.payload.sample_id >= cfg.range_a_start) &&
                    (diff_a < cfg.range_a_count);
    assign in_b   = (contrib.payload.sample_id >= cfg.range_b_start) &&
                    (diff_b < cfg.range_b_count);

    assign limit = {1'b0, cfg.tail_limit[contrib.payload.channel]};

    // stage contents
    always_comb
    begin
        prep_next.func          = contrib.payload.func;
        prep_next.sample_id     = contrib.payload.sample_id;
        prep_next.channel       = contrib.payload.channel;
        prep_next.contribution  = contrib.payload.contribution;
        prep_next.weight        = contrib.payload.weight;
        prep_next.magnitude     = mag;
        prep_next.square        = mag * mag;
        prep_next.weight_square = contrib.payload.weight * contrib.payload.weight;
        prep_next.id_in_range   = in_a || in_b;
        prep_next.tail_hit      = mag > limit;
        prep_next.excess        = mag - limit;
    end

    // occupancy
    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            prep_reg <= prep_next;
    end

    assign prep_valid = valid_reg;
    assign prep       = prep_reg;

endmodule

@@ hdl/cmta_accum.sv @@
// ----------------------------------------------------------------------------
// cmta_accum
// Second stage: sequence and order checks, saturating accumulator update and
// the result register.
// ----------------------------------------------------------------------------
module cmta_accum #(
    parameter int CHANNELS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  prep_valid,
    input  cmta_pkg::cmta_prep_t  prep,
    output logic                  advance,
    cmta_stream_if.source         stats
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // per-channel state
    logic signed [47:0] sum_reg    [CHANNELS];
    logic [63:0]        sq_reg     [CHANNELS];
    logic [31:0]        peak_reg   [CHANNELS];
    logic [31:0]        hits_reg   [CHANNELS];
    logic [47:0]        excess_reg [CHANNELS];
    logic signed [47:0] sum_next    [CHANNELS];
    logic [63:0]        sq_next     [CHANNELS];
    logic [31:0]        peak_next   [CHANNELS];
    logic [31:0]        hits_next   [CHANNELS];
    logic [47:0]        excess_next [CHANNELS];

    // shared state
    logic [31:0]          sample_total_reg, sample_total_next;
    logic [47:0]          weight_acc_reg, weight_acc_next;
    logic [63:0]          weight_sq_reg, weight_sq_next;
    logic [63:0]          last_id_reg, last_id_next;
    logic                 seen_any_reg, seen_any_next;
    logic [1:0]           next_channel_reg, next_channel_next;
    cmta_pkg::status_t    error_reg, error_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    cmta_pkg::cmta_out_t  out_reg, out_next;

    logic                 step;
    logic                 ch_ok;
    logic                 ch0;
    logic [IDX_W-1:0]     idx;
    cmta_pkg::status_t    check;
    logic                 do_clear;
    logic                 do_acc;
    logic                 do_fail;

    logic signed [47:0]   cur_sum;
    logic [63:0]          cur_sq;
    logic [31:0]          cur_peak;
    logic [31:0]          cur_hits;
    logic [47:0]          cur_excess;

    logic [48:0]          sum_wide;
    logic [64:0]          sq_wide;
    logic [48:0]          exc_wide;
    logic [48:0]          wacc_wide;
    logic [64:0]          wsq_wide;
    logic                 sum_ovf, sq_ovf, exc_ovf, wacc_ovf, wsq_ovf, ovf;
    logic signed [47:0]   sum_new;
    logic [63:0]          sq_new;
    logic [31:0]          peak_new;
    logic [31:0]          hits_new;
    logic [47:0]          excess_new;

    // the stage moves when the result register is free or being taken
    assign advance = !out_valid_reg || stats.ready;
    assign step    = prep_valid && advance;

    assign ch_ok = {1'b0, prep.channel} < 3'(CHANNELS);
    assign ch0   = prep.channel == 2'd0;
    assign idx   = prep.channel[IDX_W-1:0];

    // current state of the addressed channel
    always_comb
    begin
        cur_sum    = '0;
        cur_sq     = '0;
        cur_peak   = '0;
        cur_hits   = '0;
        cur_excess = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (ch_ok && (idx == IDX_W'(i)))
            begin
                cur_sum    = sum_reg[i];
                cur_sq     = sq_reg[i];
                cur_peak   = peak_reg[i];
                cur_hits   = hits_reg[i];
                cur_excess = excess_reg[i];
            end
        end
    end

    // sequence, order, range and weight checks in priority order
    always_comb
    begin
        check = cmta_pkg::ST_OK;
        if (prep.channel != next_channel_reg)
            check = cmta_pkg::ST_SEQUENCE;
        else if (!ch0)
            check = (prep.sample_id != last_id_reg) ? cmta_pkg::ST_SEQUENCE
                                                    : cmta_pkg::ST_OK;
        else if (seen_any_reg && (prep.sample_id <= last_id_reg))
            check = cmta_pkg::ST_ORDER;
        else if (!prep.id_in_range)
            check = cmta_pkg::ST_RANGE;
        else if (prep.weight == 32'd0)
            check = cmta_pkg::ST_WEIGHT;
    end

    assign do_clear = prep.func == cmta_pkg::FUNC_CLEAR;
    assign do_acc   = !do_clear && (error_reg == cmta_pkg::ST_OK) &&
                      (check == cmta_pkg::ST_OK);
    assign do_fail  = !do_clear && (error_reg == cmta_pkg::ST_OK) &&
                      (check != cmta_pkg::ST_OK);

    // saturating sums
    assign sum_wide  = {cur_sum[47], cur_sum} + {{17{prep.contribution[31]}},
                                                 prep.contribution};
    assign sum_ovf   = sum_wide[48] ^ sum_wide[47];
    assign sum_new   = !sum_ovf ? sum_wide[47:0]
                     : (sum_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});

    assign sq_wide   = {1'b0, cur_sq} + {1'b0, prep.square};
    assign sq_ovf    = sq_wide[64];
    assign sq_new    = sq_ovf ? '1 : sq_wide[63:0];

    assign exc_wide  = {1'b0, cur_excess} + {17'd0, prep.excess};
    assign exc_ovf   = prep.tail_hit && exc_wide[48];

    assign wacc_wide = {1'b0, weight_acc_reg} + {17'd0, prep.weight};
    assign wacc_ovf  = ch0 && wacc_wide[48];

    assign wsq_wide  = {1'b0, weight_sq_reg} + {1'b0, prep.weight_square};
    assign wsq_ovf   = ch0 && wsq_wide[64];

    assign ovf = sum_ovf || sq_ovf || exc_ovf || wacc_ovf || wsq_ovf;

    // peak and tail statistics
    always_comb
    begin
        peak_new   = (prep.magnitude > cur_peak) ? prep.magnitude : cur_peak;
        hits_new   = cur_hits;
        excess_new = cur_excess;
        if (prep.tail_hit)
        begin
            if (cur_hits != '1)
                hits_new = cur_hits + 32'd1;
            excess_new = exc_wide[48] ? '1 : exc_wide[47:0];
        end
    end

    // next per-channel state
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            sum_next[i]    = sum_reg[i];
            sq_next[i]     = sq_reg[i];
            peak_next[i]   = peak_reg[i];
            hits_next[i]   = hits_reg[i];
            excess_next[i] = excess_reg[i];
            if (do_clear)
            begin
                sum_next[i]    = '0;
                sq_next[i]     = '0;
                peak_next[i]   = '0;
                hits_next[i]   = '0;
                excess_next[i] = '0;
            end
            else if (do_acc && (idx == IDX_W'(i)))
            begin
                sum_next[i]    = sum_new;
                sq_next[i]     = sq_new;
                peak_next[i]   = peak_new;
                hits_next[i]   = hits_new;
                excess_next[i] = excess_new;
            end
        end
    end

    // next shared state
    always_comb
    begin
        sample_total_next = sample_total_reg;
        weight_acc_next   = weight_acc_reg;
        weight_sq_next    = weight_sq_reg;
        last_id_next      = last_id_reg;
        seen_any_next     = seen_any_reg;
        next_channel_next = next_channel_reg;
        error_next        = error_reg;
        if (do_clear)
        begin
            sample_total_next = '0;
            weight_acc_next   = '0;
            weight_sq_next    = '0;
            last_id_next      = '0;
            seen_any_next     = 1'b0;
            next_channel_next = '0;
            error_next        = cmta_pkg::ST_OK;
        end
        else if (do_fail)
        begin
            error_next = check;
        end
        else if (do_acc)
        begin
            if (ch0)
            begin
                if (sample_total_reg != '1)
                    sample_total_next = sample_total_reg + 32'd1;
                weight_acc_next = wacc_wide[48] ? '1 : wacc_wide[47:0];
                weight_sq_next  = wsq_wide[64] ? '1 : wsq_wide[63:0];
                last_id_next    = prep.sample_id;
                seen_any_next   = 1'b1;
            end
            if (({1'b0, prep.channel} + 3'd1) >= 3'(CHANNELS))
                next_channel_next = '0;
            else
                next_channel_next = prep.channel + 2'd1;
            if (ovf)
                error_next = cmta_pkg::ST_OVERFLOW;
        end
    end

    // result from the state after this request
    always_comb
    begin
        out_next.status              = error_next;
        out_next.samples_seen        = sample_total_next;
        out_next.running_sum         = '0;
        out_next.running_square_sum  = '0;
        out_next.peak_magnitude      = '0;
        out_next.tail_hits           = '0;
        out_next.tail_excess_total   = '0;
        out_next.weight_total        = weight_acc_next;
        out_next.weight_square_total = weight_sq_next;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (ch_ok && (idx == IDX_W'(i)))
            begin
                out_next.running_sum        = sum_next[i];
                out_next.running_square_sum = sq_next[i];
                out_next.peak_magnitude     = peak_next[i];
                out_next.tail_hits          = hits_next[i];
                out_next.tail_excess_total  = excess_next[i];
            end
        end
    end

    // result occupancy
    always_comb
    begin
        if (step)
            out_valid_next = 1'b1;
        else if (stats.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i]    <= '0;
                sq_reg[i]     <= '0;
                peak_reg[i]   <= '0;
                hits_reg[i]   <= '0;
                excess_reg[i] <= '0;
            end
            sample_total_reg <= '0;
            weight_acc_reg   <= '0;
            weight_sq_reg    <= '0;
            last_id_reg      <= '0;
            seen_any_reg     <= 1'b0;
            next_channel_reg <= '0;
            error_reg        <= cmta_pkg::ST_OK;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    sum_reg[i]    <= sum_next[i];
                    sq_reg[i]     <= sq_next[i];
                    peak_reg[i]   <= peak_next[i];
                    hits_reg[i]   <= hits_next[i];
                    excess_reg[i] <= excess_next[i];
                end
                sample_total_reg <= sample_total_next;
                weight_acc_reg   <= weight_acc_next;
                weight_sq_reg    <= weight_sq_next;
                last_id_reg      <= last_id_next;
                seen_any_reg     <= seen_any_next;
                next_channel_reg <= next_channel_next;
                error_reg        <= error_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= out_next;
    end

    assign stats.valid   = out_valid_reg;
    assign stats.payload = out_reg;

endmodule

@@ hdl/channel_moment_tail_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// channel_moment_tail_accumulator_top
// Running moment and tail statistics over per-channel sample contributions.
// ----------------------------------------------------------------------------
// The block takes one request per clock while results are taken and returns
// one result per request: a first stage registers the contribution's
// magnitude, both squares and the range and tail checks, a second stage
// updates the saturating accumulators and loads the result register. The
// one-cycle rate is set by the accumulator feedback in the second stage,
// where each request sees the state left by the one before it. A result
// that is not taken holds the pipeline; up to two requests are in flight.
// There are no memories and no clearing pass after reset. The user must write
// configuration only while no request is in flight; the block has no check.
module channel_moment_tail_accumulator_top #(
    parameter int CHANNELS = 4,
    parameter int RANGES   = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    cmta_stream_if.sink   contrib,
    cmta_stream_if.source stats
);

    cmta_pkg::cmta_cfg_t  cfg;
    cmta_pkg::cmta_prep_t prep;
    logic                 prep_valid;
    logic                 advance;

    // configuration registers
    cmta_cfg_regs #(
        .CHANNELS (CHANNELS),
        .RANGES   (RANGES)
    ) u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // first stage
    cmta_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .contrib    (contrib),
        .cfg        (cfg),
        .advance    (advance),
        .prep_valid (prep_valid),
        .prep       (prep)
    );

    // accumulators and result register
    cmta_accum #(
        .CHANNELS (CHANNELS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .prep_valid (prep_valid),
        .prep       (prep),
        .advance    (advance),
        .stats      (stats)
    );

endmodule

@@ hdl/cmta_checker.sv @@
// ----------------------------------------------------------------------------
// cmta_checker
// Port-level checks of the accumulator: in-flight depth, latched status,
// sample count progression and result hold under stall.
// ----------------------------------------------------------------------------
module cmta_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input cmta_pkg::cmta_out_t out_payload
);

    logic        in_take;
    logic        out_take;
    logic [1:0]  inflight_reg, inflight_next;
    logic        have_last_reg;
    logic [2:0]  last_status_reg;
    logic [31:0] last_samples_reg;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    // requests taken and not yet answered
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_take && !out_take)
            inflight_next = inflight_reg + 2'd1;
        else if (!in_take && out_take)
            inflight_next = inflight_reg - 2'd1;
    end

    // last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg     <= '0;
            have_last_reg    <= 1'b0;
            last_status_reg  <= '0;
            last_samples_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            if (out_take)
            begin
                have_last_reg    <= 1'b1;
                last_status_reg  <= out_payload.status;
                last_samples_reg <= out_payload.samples_seen;
            end
        end
    end

    // pipeline holds at most two requests and never answers one not taken
    a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg != 2'd3) && (!out_valid || (inflight_reg != 2'd0)))
        else $error("in-flight count out of bounds");

    // a latched error stays until a clear zeroes the result
    a_error_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && have_last_reg && (last_status_reg != cmta_pkg::ST_OK)) |->
        ((out_payload.status == last_status_reg) ||
         ((out_payload.status == cmta_pkg::ST_OK) && (out_payload.samples_seen == '0))))
        else $error("latched status changed without clear");

    // sample count stays, steps by one, or clears
    a_samples_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && have_last_reg) |->
        ((out_payload.samples_seen == last_samples_reg) ||
         (out_payload.samples_seen == 32'(last_samples_reg + 32'd1)) ||
         (out_payload.samples_seen == '0)))
        else $error("sample count jumped");

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_payload)))
        else $error("stalled result changed");

endmodule

bind channel_moment_tail_accumulator_top cmta_checker u_cmta_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (contrib.valid),
    .in_ready    (contrib.ready),
    .out_valid   (stats.valid),
    .out_ready   (stats.ready),
    .out_payload (stats.payload)
);

@@ tb/cmta_stats_checker.sv @@
// ----------------------------------------------------------------------------
// cmta_stats_checker
// Watches the configuration port, request and result channels of the channel
// moment and tail accumulator. It keeps its own copy of the per-channel
// moments, tail counts, weight sums and sequence tracking, predicts the
// result of every accepted request and compares each returned result with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module cmta_stats_checker
    import cmta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [63:0] cfg_data,
    input  logic       req_valid,
    input  logic       req_ready,
    input  cmta_in_t   req_payload,
    input  logic       res_valid,
    input  logic       res_ready,
    input  cmta_out_t  res_payload,
    output int         outstanding,
    output int         fail_count
);

    localparam int CHANNELS = 4;

    // configuration copy
    logic [63:0] range_a_start;
    logic [63:0] range_a_count;
    logic [63:0] range_b_start;
    logic [63:0] range_b_count;
    logic [30:0] tail_limit [CHANNELS];

    // accumulator copy
    logic signed [47:0] chan_sum    [CHANNELS];
    logic [63:0]        chan_sq     [CHANNELS];
    logic [31:0]        chan_peak   [CHANNELS];
    logic [31:0]        chan_hits   [CHANNELS];
    logic [47:0]        chan_excess [CHANNELS];
    logic [31:0]        samples_acc;
    logic [47:0]        weight_acc;
    logic [63:0]        weight_sq_acc;
    logic [63:0]        last_id;
    logic               id_seen;
    logic [1:0]         next_ch;
    status_t            err_code;

    // results still owed by the block, oldest first
    cmta_out_t stats_due [$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    // zero every accumulator and the sequence tracking
    task automatic clear_moments();
        for (int i = 0; i < CHANNELS; i++)
        begin
            chan_sum[i]    = '0;
            chan_sq[i]     = '0;
            chan_peak[i]   = '0;
            chan_hits[i]   = '0;
            chan_excess[i] = '0;
        end
        samples_acc   = '0;
        weight_acc    = '0;
        weight_sq_acc = '0;
        last_id       = '0;
        id_seen       = 1'b0;
        next_ch       = '0;
        err_code      = ST_OK;
    endtask

    // sequence, order, range and weight checks in priority order
    function automatic status_t check_request(input cmta_in_t req);
        logic in_a;
        logic in_b;
        in_a = (req.sample_id >= range_a_start) &&
               ((req.sample_id - range_a_start) < range_a_count);
        in_b = (req.sample_id >= range_b_start) &&
               ((req.sample_id - range_b_start) < range_b_count);
        if (req.channel != next_ch)
            return ST_SEQUENCE;
        if (req.channel != 2'd0)
        begin
            if (req.sample_id != last_id)
                return ST_SEQUENCE;
            return ST_OK;
        end
        if (id_seen && req.sample_id <= last_id)
            return ST_ORDER;
        if (!(in_a || in_b))
            return ST_RANGE;
        if (req.weight == 32'd0)
            return ST_WEIGHT;
        return ST_OK;
    endfunction

    // apply one request to the accumulator copy and form its result
    task automatic update_moments(input cmta_in_t req, output cmta_out_t res);
        logic [1:0]  ch;
        logic [31:0] mag;
        logic [63:0] sq;
        logic [63:0] w_sq;
        logic [48:0] sum_ext;
        logic [48:0] wide48;
        logic [64:0] wide64;
        logic        ovf;
        status_t     verdict;
        ch  = req.channel;
        ovf = 1'b0;
        if (req.func == FUNC_CLEAR)
            clear_moments();
        else if (err_code == ST_OK)
        begin
            verdict = check_request(req);
            if (verdict != ST_OK)
                err_code = verdict;
            else
            begin
                mag = req.contribution[31] ? (~req.contribution + 32'd1) : req.contribution;
                sq  = {32'd0, mag} * {32'd0, mag};

                // sample bookkeeping and weight sums on channel 0
                if (ch == 2'd0)
                begin
                    if (samples_acc != '1)
                        samples_acc = samples_acc + 32'd1;
                    wide48 = {1'b0, weight_acc} + {17'd0, req.weight};
                    if (wide48[48])
                    begin
                        weight_acc = '1;
                        ovf        = 1'b1;
                    end
                    else
                        weight_acc = wide48[47:0];
                    w_sq   = {32'd0, req.weight} * {32'd0, req.weight};
                    wide64 = {1'b0, weight_sq_acc} + {1'b0, w_sq};
                    if (wide64[64])
                    begin
                        weight_sq_acc = '1;
                        ovf           = 1'b1;
                    end
                    else
                        weight_sq_acc = wide64[63:0];
                    last_id = req.sample_id;
                    id_seen = 1'b1;
                end

                // signed running sum, clamped at both ends
                sum_ext = {chan_sum[ch][47], chan_sum[ch]} +
                          {{17{req.contribution[31]}}, req.contribution};
                if (sum_ext[48] != sum_ext[47])
                begin
                    chan_sum[ch] = sum_ext[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                    ovf          = 1'b1;
                end
                else
                    chan_sum[ch] = sum_ext[47:0];

                // square sum
                wide64 = {1'b0, chan_sq[ch]} + {1'b0, sq};
                if (wide64[64])
                begin
                    chan_sq[ch] = '1;
                    ovf         = 1'b1;
                end
                else
                    chan_sq[ch] = wide64[63:0];

                if (mag > chan_peak[ch])
                    chan_peak[ch] = mag;

                // tail hit only strictly above the threshold
                if (mag > {1'b0, tail_limit[ch]})
                begin
                    if (chan_hits[ch] != '1)
                        chan_hits[ch] = chan_hits[ch] + 32'd1;
                    wide48 = {1'b0, chan_excess[ch]} + {17'd0, mag - {1'b0, tail_limit[ch]}};
                    if (wide48[48])
                    begin
                        chan_excess[ch] = '1;
                        ovf             = 1'b1;
                    end
                    else
                        chan_excess[ch] = wide48[47:0];
                end

                next_ch = (ch == 2'(CHANNELS - 1)) ? 2'd0 : ch + 2'd1;
                if (ovf)
                    err_code = ST_OVERFLOW;
            end
        end

        res.status              = err_code;
        res.samples_seen        = samples_acc;
        res.running_sum         = chan_sum[ch];
        res.running_square_sum  = chan_sq[ch];
        res.peak_magnitude      = chan_peak[ch];
        res.tail_hits           = chan_hits[ch];
        res.tail_excess_total   = chan_excess[ch];
        res.weight_total        = weight_acc;
        res.weight_square_total = weight_sq_acc;
    endtask

    // one field of a result against its prediction
    task automatic check_field(input string field, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t %s: expected %h, actual %h", $time, field, want_v, got_v);
            fail_count++;
        end
    endtask

    // compare results, track registers, predict new requests
    always @(posedge clk or negedge rst_n)
    begin : watch
        cmta_out_t want;
        if (!rst_n)
        begin
            range_a_start = '0;
            range_a_count = '0;
            range_b_start = '0;
            range_b_count = '0;
            for (int i = 0; i < CHANNELS; i++)
                tail_limit[i] = '0;
            clear_moments();
            stats_due.delete();
            outstanding = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (stats_due.size() == 0)
                begin
                    $display("%0t result with nothing pending: actual status %0d",
                             $time, res_payload.status);
                    fail_count++;
                end
                else
                begin
                    want = stats_due.pop_front();
                    check_field("status", want.status, res_payload.status);
                    check_field("samples_seen", want.samples_seen,
                                res_payload.samples_seen);
                    check_field("running_sum", want.running_sum, res_payload.running_sum);
                    check_field("running_square_sum", want.running_square_sum,
                                res_payload.running_square_sum);
                    check_field("peak_magnitude", want.peak_magnitude,
                                res_payload.peak_magnitude);
                    check_field("tail_hits", want.tail_hits, res_payload.tail_hits);
                    check_field("tail_excess_total", want.tail_excess_total,
                                res_payload.tail_excess_total);
                    check_field("weight_total", want.weight_total,
                                res_payload.weight_total);
                    check_field("weight_square_total", want.weight_square_total,
                                res_payload.weight_square_total);
                end
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_RANGE_A_START: range_a_start = cfg_data;
                    REG_RANGE_A_COUNT: range_a_count = cfg_data;
                    REG_RANGE_B_START: range_b_start = cfg_data;
                    REG_RANGE_B_COUNT: range_b_count = cfg_data;
                    REG_TAIL_LIMIT_0:  tail_limit[0] = cfg_data[30:0];
                    REG_TAIL_LIMIT_1:  tail_limit[1] = cfg_data[30:0];
                    REG_TAIL_LIMIT_2:  tail_limit[2] = cfg_data[30:0];
                    REG_TAIL_LIMIT_3:  tail_limit[3] = cfg_data[30:0];
                    default: ;
                endcase
            end

            if (req_valid && req_ready)
            begin
                update_moments(req_payload, want);
                stats_due.insert(stats_due.size(), want);
            end
            outstanding = stats_due.size();
        end
    end

endmodule

@@ tb/tb_channel_moment_tail_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// tb_channel_moment_tail_accumulator_top
// Drives the channel moment and tail accumulator with a directed set of
// edge cases, then with random four-channel samples mixed with clears and
// broken sequences, over three register settings and three idle patterns.
// A checker module predicts and compares every result; this module gives
// the verdict.
// ----------------------------------------------------------------------------
module tb_channel_moment_tail_accumulator_top;
    import cmta_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int outstanding;
    int fail_count;

    // sample identity generation
    logic [63:0] id_base;
    logic [63:0] id_alt;
    logic [63:0] id_cursor;
    logic        alt_enabled;
    logic        on_alt;
    logic        fresh;

    cmta_stream_if #(.payload_t(cmta_in_t))  contrib_if ();
    cmta_stream_if #(.payload_t(cmta_out_t)) stats_if ();

    channel_moment_tail_accumulator_top #(
        .CHANNELS(4),
        .RANGES(2)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .contrib(contrib_if),
        .stats(stats_if)
    );

    cmta_stats_checker stats_check (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req_valid(contrib_if.valid),
        .req_ready(contrib_if.ready),
        .req_payload(contrib_if.payload),
        .res_valid(stats_if.valid),
        .res_ready(stats_if.ready),
        .res_payload(stats_if.payload),
        .outstanding(outstanding),
        .fail_count(fail_count)
    );

    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    // result side stalls
    initial
    begin
        stats_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stats_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // one request, with random idle cycles ahead of it
    task automatic send_req(input func_t fn, input logic [63:0] id, input logic [1:0] ch,
                            input logic [31:0] value, input logic [31:0] wt);
        cmta_in_t req;
        req.func         = fn;
        req.sample_id    = id;
        req.channel      = ch;
        req.contribution = value;
        req.weight       = wt;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            contrib_if.valid <= 1'b0;
            @(negedge clk);
        end
        contrib_if.valid   <= 1'b1;
        contrib_if.payload <= req;
        do
            @(posedge clk);
        while (!contrib_if.ready);
        @(negedge clk);
        items_sent++;
    endtask

    // stop sending and wait for every owed result
    task automatic settle();
        contrib_if.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic put_reg(input reg_index_t idx, input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic write_all(input logic [63:0] a_start, input logic [63:0] a_count,
                             input logic [63:0] b_start, input logic [63:0] b_count,
                             input logic [63:0] lim0, input logic [63:0] lim1,
                             input logic [63:0] lim2, input logic [63:0] lim3);
        put_reg(REG_RANGE_A_START, a_start);
        put_reg(REG_RANGE_A_COUNT, a_count);
        put_reg(REG_RANGE_B_START, b_start);
        put_reg(REG_RANGE_B_COUNT, b_count);
        put_reg(REG_TAIL_LIMIT_0, lim0);
        put_reg(REG_TAIL_LIMIT_1, lim1);
        put_reg(REG_TAIL_LIMIT_2, lim2);
        put_reg(REG_TAIL_LIMIT_3, lim3);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // mostly moderate magnitudes, sometimes full scale
    function automatic logic [31:0] rand_contrib();
        int unsigned pick;
        logic [31:0] v;
        pick = $urandom_range(99, 0);
        if (pick < 2)
            return 32'h8000_0000;
        if (pick < 4)
            return 32'h7FFF_FFFF;
        if (pick < 8)
            return $urandom;
        v = $urandom >> $urandom_range(31, 8);
        return pick[0] ? -v : v;
    endfunction

    // nonzero weight, mostly small so the square sum lasts
    function automatic logic [31:0] rand_weight();
        logic [31:0] v;
        if ($urandom_range(99, 0) < 4)
        begin
            v = $urandom;
            if (v == 32'd0)
                v = 32'd1;
            return v;
        end
        return $urandom_range(32'h000F_FFFF, 1);
    endfunction

    // clear request, restarts the identity sequence
    task automatic send_clear();
        send_req(FUNC_CLEAR, {$urandom, $urandom}, 2'($urandom), $urandom, $urandom);
        id_cursor = id_base;
        on_alt    = 1'b0;
        fresh     = 1'b1;
    endtask

    // well-formed sample: channels 0 to 3 with one rising identity
    task automatic send_sample();
        int unsigned min_step;
        min_step = fresh ? 0 : 1;
        if (alt_enabled && !on_alt && $urandom_range(15, 0) == 0)
        begin
            id_cursor = id_alt;
            on_alt    = 1'b1;
            min_step  = 0;
        end
        id_cursor = id_cursor + $urandom_range(16, min_step);
        fresh     = 1'b0;
        send_req(FUNC_ACCUM, id_cursor, 2'd0, rand_contrib(), rand_weight());
        for (int ch = 1; ch < MAX_CHANNELS; ch++)
            send_req(FUNC_ACCUM, id_cursor, 2'(ch), rand_contrib(), $urandom);
    endtask

    // broken sequence, one more request on the latched error, then a clear
    task automatic send_broken();
        case ($urandom_range(5, 0))
            0: send_req(FUNC_ACCUM, id_cursor, 2'd0, rand_contrib(), rand_weight());
            1: send_req(FUNC_ACCUM, {$urandom, $urandom}, 2'd0, rand_contrib(), rand_weight());
            2:
            begin
                id_cursor = id_cursor + 64'd1;
                send_req(FUNC_ACCUM, id_cursor, 2'd0, rand_contrib(), 32'd0);
            end
            3:
            begin
                id_cursor = id_cursor + 64'd1;
                send_req(FUNC_ACCUM, id_cursor, 2'd0, rand_contrib(), rand_weight());
                send_req(FUNC_ACCUM, id_cursor, 2'd1, rand_contrib(), $urandom);
                send_req(FUNC_ACCUM, id_cursor, 2'd3, rand_contrib(), $urandom);
            end
            4:
            begin
                id_cursor = id_cursor + 64'd1;
                send_req(FUNC_ACCUM, id_cursor, 2'd0, rand_contrib(), rand_weight());
                send_req(FUNC_ACCUM, id_cursor + 64'd1, 2'd1, rand_contrib(), $urandom);
            end
            default:
                send_req(FUNC_ACCUM, {$urandom, $urandom}, 2'($urandom), $urandom, $urandom);
        endcase
        send_req(FUNC_ACCUM, {$urandom, $urandom}, 2'($urandom), rand_contrib(), $urandom);
        send_clear();
    endtask

    // random traffic until the request count reaches the target
    task automatic run_traffic(input int target);
        int unsigned pick;
        while (items_sent < target)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 5)
                send_clear();
            else if (pick < 13)
                send_broken();
            else
                send_sample();
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        contrib_if.valid   = 1'b0;
        contrib_if.payload = '0;
        items_sent         = 0;
        send_idle_pct      = 37;
        recv_idle_pct      = 69;
        id_base            = '0;
        id_alt             = '0;
        id_cursor          = '0;
        alt_enabled        = 1'b0;
        on_alt             = 1'b0;
        fresh              = 1'b1;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // low range A, range B at the top bit, tail limits zero and full scale
        write_all(64'h0000_0000_0000_1000, 64'h0000_0000_0001_0000,
                  64'h8000_0000_0000_0000, 64'h0000_0001_0000_0000,
                  64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0001_0000,
                  {$urandom, $urandom});
        id_base     = 64'h0000_0000_0000_1000;
        id_alt      = 64'h8000_0000_0000_0000;
        alt_enabled = 1'b1;

        // directed: full-scale values and threshold edges
        send_clear();
        send_req(FUNC_ACCUM, 64'h1000, 2'd0, 32'h7FFF_FFFF, 32'd1);
        send_req(FUNC_ACCUM, 64'h1000, 2'd1, 32'h8000_0000, 32'hFFFF_FFFF);
        send_req(FUNC_ACCUM, 64'h1000, 2'd2, 32'hFFFF_0000, 32'd0);
        send_req(FUNC_ACCUM, 64'h1000, 2'd3, 32'h0, 32'h0);
        send_req(FUNC_ACCUM, 64'h1001, 2'd0, 32'h8000_0000, 32'hFFFF_FFFF);
        send_req(FUNC_ACCUM, 64'h1001, 2'd1, 32'h7FFF_FFFF, 32'h0);
        send_req(FUNC_ACCUM, 64'h1001, 2'd2, 32'h0001_0001, 32'h0);
        send_req(FUNC_ACCUM, 64'h1001, 2'd3, 32'hFFFF_FFFF, 32'h0);
        // identity not rising
        send_req(FUNC_ACCUM, 64'h1001, 2'd0, 32'h1, 32'd1);
        send_clear();
        // identity in no range
        send_req(FUNC_ACCUM, 64'h0, 2'd0, 32'h1, 32'd5);
        send_clear();
        // zero weight
        send_req(FUNC_ACCUM, 64'h1000, 2'd0, 32'h1, 32'd0);
        send_clear();
        // sample starting on the wrong channel
        send_req(FUNC_ACCUM, 64'h1000, 2'd1, 32'h1, 32'd1);
        send_clear();
        // identity changing inside a sample
        send_req(FUNC_ACCUM, 64'h1000, 2'd0, 32'h1, 32'd1);
        send_req(FUNC_ACCUM, 64'h1002, 2'd1, 32'h1, 32'd1);
        send_clear();
        // weight square sum saturates, error stays latched
        send_req(FUNC_ACCUM, 64'h2000, 2'd0, 32'h8000_0000, 32'hFFFF_FFFF);
        send_req(FUNC_ACCUM, 64'h2000, 2'd1, 32'h0123_4567, 32'h0);
        send_req(FUNC_ACCUM, 64'h2000, 2'd2, 32'hFEDC_BA98, 32'h0);
        send_req(FUNC_ACCUM, 64'h2000, 2'd3, 32'h0000_8000, 32'h0);
        send_req(FUNC_ACCUM, 64'h2001, 2'd0, 32'h1, 32'hFFFF_FFFF);
        send_req(FUNC_ACCUM, 64'h2001, 2'd1, 32'h1, 32'h0);
        send_clear();

        // random, sender idles less than receiver, with a full drain midway
        run_traffic(130);
        settle();
        run_traffic(210);
        settle();

        // range A up to the last identity, range B off, other limits
        send_idle_pct = 69;
        recv_idle_pct = 37;
        write_all(64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'h5555_0000_0000_0000, 64'h0,
                  64'h7FFF_FFFF, 64'h0, 64'h0000_0000_00FF_FFFF, 64'h100);
        id_base     = 64'hFFFF_FFFF_FFFF_F000;
        alt_enabled = 1'b0;
        send_clear();
        run_traffic(390);
        settle();

        // range A off, range B covering almost everything, no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(64'h0, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'h0001_0000, 64'h7FFF_FFFF, 64'h0, 64'h00FF_FFFF);
        id_base     = 64'h0;
        id_alt      = 64'h7FFF_FFFF_FFFF_0000;
        alt_enabled = 1'b1;
        send_clear();
        run_traffic(560);
        settle();

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/cmta_pkg.sv
hdl/cmta_stream_if.sv
hdl/cmta_cfg_regs.sv
hdl/cmta_prep.sv
hdl/cmta_accum.sv
hdl/channel_moment_tail_accumulator_top.sv
hdl/cmta_checker.sv
tb/cmta_stats_checker.sv
tb/tb_channel_moment_tail_accumulator_top.sv
